@@ rtl/core/mts_pkg.sv @@
// shared types, constants and pattern function for the memory test sequencer
package mts_pkg;

    localparam int ADDR_BITS = 17;

    // word index and count widths: the count register is 16 bits, index may overshoot by one stride
    localparam int CNT_W = 17;
    localparam int IDX_W = 17;
    localparam longint unsigned WORD_CAP = 64'(1) << (ADDR_BITS - 2);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam int S_FIELDS_W = 1 + 32;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ADDR_BITS + 32 + 1 + 1 + 2 + ADDR_BITS;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 3;

    localparam logic [15:0] WORD_COUNT_RST  = 16'd32768;
    localparam logic [15:0] WORD_STRIDE_RST = 16'd256;
    localparam logic [3:0]  PASS_COUNT_RST  = 4'd5;
    localparam logic [7:0]  BYTE_SPAN_RST   = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORD_COUNT  = 8'd0,
        REG_WORD_STRIDE = 8'd1,
        REG_PASS_COUNT  = 8'd2,
        REG_BYTE_SPAN   = 8'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FAIL_NONE = 2'd0,
        FAIL_WORD = 2'd1,
        FAIL_BYTE = 2'd2
    } fail_kind_t;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_WWR  = 6'b000010,
        PH_WRD  = 6'b000100,
        PH_BWR  = 6'b001000,
        PH_BRD  = 6'b010000,
        PH_DONE = 6'b100000
    } phase_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic logic is_running(input phase_t ph);
        return (ph == PH_WWR) || (ph == PH_WRD) || (ph == PH_BWR) || (ph == PH_BRD);
    endfunction

endpackage

@@ rtl/core/memory_test_sequencer.sv @@
// memory self-test sequencer: xorshift32 word passes followed by a byte walk
// a result transaction is registered in the output register after its input transaction
// has passed the input register, when the output register is free to take it
// throughput: one slot per cycle while the output does not stall (one state update per slot)
// a stalled output leaves one more input transaction parked in the input register
// reset (aresetn low, synchronous) returns to idle with cleared status and reset config
module memory_test_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mts_pkg::S_TDATA_W-1:0]   s_tdata,   // go, read_data, zero pad
    input  logic                            s_tuser,   // read_valid
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // req_addr, req_wdata, busy_res, done_res, fail_kind, fail_addr, zero pad
    output logic [mts_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [mts_pkg::M_TUSER_W-1:0]   m_tuser    // req_valid, req_write, req_byte
);
    import mts_pkg::*;

    // configuration
    logic [15:0] word_count_reg, word_stride_reg;
    logic [3:0]  pass_count_reg;
    logic [7:0]  byte_span_reg;

    // input register
    logic        in_valid_reg, in_go_reg, in_rvalid_reg;
    logic [31:0] in_rdata_reg;

    // sequencer state
    phase_t                 phase_reg, phase_next;
    logic [3:0]             pass_reg, pass_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [31:0]            prng_reg, prng_next;
    logic [31:0]            exp_reg, exp_next;
    logic [7:0]             bi_reg, bi_next;
    logic                   pend_reg, pend_next;
    logic [1:0]             fk_reg, fk_next;
    logic [ADDR_BITS-1:0]   fa_reg, fa_next;

    // output register
    logic                   m_valid_reg;
    logic                   rq_v_reg, rq_w_reg, rq_b_reg;
    logic [ADDR_BITS-1:0]   rq_a_reg;
    logic [31:0]            rq_d_reg;
    logic                   busy_reg, done_reg;

    logic                   rq_v, rq_w, rq_b;
    logic [ADDR_BITS-1:0]   rq_a;
    logic [31:0]            rq_d;

    logic                   advance;
    logic [CNT_W-1:0]       cnt_eff;
    logic [IDX_W-1:0]       stride_eff;
    logic [31:0]            xs_state, xs_seed, xs_seed_inc;
    logic [3:0]             pass_inc;
    logic                   go_bytes, brd_check;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    assign cnt_eff    = (64'(word_count_reg) < WORD_CAP) ? CNT_W'(word_count_reg)
                                                         : CNT_W'(WORD_CAP);
    assign stride_eff = (word_stride_reg == 16'd0) ? IDX_W'(1) : IDX_W'(word_stride_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_count_reg  <= WORD_COUNT_RST;
            word_stride_reg <= WORD_STRIDE_RST;
            pass_count_reg  <= PASS_COUNT_RST;
            byte_span_reg   <= BYTE_SPAN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WORD_COUNT:  word_count_reg  <= cfg_data;
                REG_WORD_STRIDE: word_stride_reg <= cfg_data;
                REG_PASS_COUNT:  pass_count_reg  <= cfg_data[3:0];
                REG_BYTE_SPAN:   byte_span_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_go_reg     <= s_tdata[0];
            in_rdata_reg  <= s_tdata[32:1];
            in_rvalid_reg <= s_tuser;
        end
    end

    // one slot of the sequencer: resolve a pending read, take a start, issue a request
    always_comb begin
        phase_next = phase_reg;
        pass_next  = pass_reg;
        idx_next   = idx_reg;
        prng_next  = prng_reg;
        exp_next   = exp_reg;
        bi_next    = bi_reg;
        pend_next  = pend_reg;
        fk_next    = fk_reg;
        fa_next    = fa_reg;
        rq_v       = 1'b0;
        rq_w       = 1'b0;
        rq_b       = 1'b0;
        rq_a       = '0;
        rq_d       = '0;
        go_bytes   = 1'b0;
        brd_check  = 1'b0;
        pass_inc   = pass_reg + 4'd1;

        if (is_running(phase_reg) && pend_reg && in_rvalid_reg) begin
            pend_next = 1'b0;
            if (phase_reg == PH_WRD) begin
                if (in_rdata_reg == exp_reg) begin
                    idx_next = idx_reg + stride_eff;
                end else begin
                    fk_next    = FAIL_WORD;
                    fa_next    = ADDR_BITS'({idx_reg, 2'b00});
                    phase_next = PH_DONE;
                end
            end else if (phase_reg == PH_BRD) begin
                if (in_rdata_reg[7:0] == exp_reg[7:0]) begin
                    bi_next = bi_reg + 8'd1;
                end else begin
                    fk_next    = FAIL_BYTE;
                    fa_next    = ADDR_BITS'(bi_reg);
                    phase_next = PH_DONE;
                end
            end
        end

        if ((phase_next == PH_IDLE || phase_next == PH_DONE) && in_go_reg) begin
            fk_next   = FAIL_NONE;
            fa_next   = '0;
            pend_next = 1'b0;
            idx_next  = '0;
            bi_next   = '0;
            exp_next  = '0;
            if (pass_count_reg == 4'd0) begin
                pass_next  = 4'd0;
                prng_next  = '0;
                phase_next = PH_BWR;
            end else begin
                pass_next  = 4'd1;
                prng_next  = 32'd1;
                phase_next = PH_WWR;
            end
        end

        xs_state    = xorshift32(prng_next);
        xs_seed     = xorshift32(32'(pass_next));
        xs_seed_inc = xorshift32(32'(pass_inc));

        if (is_running(phase_next) && !pend_next) begin
            unique case (phase_next)
                PH_WWR: begin
                    if (CNT_W'(idx_next) < cnt_eff) begin
                        rq_v      = 1'b1;
                        rq_w      = 1'b1;
                        rq_a      = ADDR_BITS'({idx_next, 2'b00});
                        rq_d      = xs_state;
                        prng_next = xs_state;
                        idx_next  = idx_next + stride_eff;
                    end else if (cnt_eff != '0) begin
                        // write sweep over, reseed and read back from index zero
                        rq_v       = 1'b1;
                        rq_a       = '0;
                        idx_next   = '0;
                        prng_next  = xs_seed;
                        exp_next   = xs_seed;
                        pend_next  = 1'b1;
                        phase_next = PH_WRD;
                    end else begin
                        go_bytes = 1'b1;
                    end
                end
                PH_WRD: begin
                    if (CNT_W'(idx_next) < cnt_eff) begin
                        rq_v      = 1'b1;
                        rq_a      = ADDR_BITS'({idx_next, 2'b00});
                        prng_next = xs_state;
                        exp_next  = xs_state;
                        pend_next = 1'b1;
                    end else if (pass_next >= pass_count_reg || cnt_eff == '0) begin
                        go_bytes = 1'b1;
                    end else begin
                        // next pass starts with its first write at index zero
                        pass_next  = pass_inc;
                        rq_v       = 1'b1;
                        rq_w       = 1'b1;
                        rq_a       = '0;
                        rq_d       = xs_seed_inc;
                        prng_next  = xs_seed_inc;
                        idx_next   = stride_eff;
                        phase_next = PH_WWR;
                    end
                end
                PH_BWR: begin
                    if (bi_next < byte_span_reg) begin
                        rq_v    = 1'b1;
                        rq_w    = 1'b1;
                        rq_b    = 1'b1;
                        rq_a    = ADDR_BITS'(bi_next);
                        rq_d    = 32'(bi_next);
                        bi_next = bi_next + 8'd1;
                    end else begin
                        bi_next    = '0;
                        phase_next = PH_BRD;
                        brd_check  = 1'b1;
                    end
                end
                PH_BRD: brd_check = 1'b1;
                default: ;
            endcase
        end

        if (go_bytes) begin
            bi_next = '0;
            if (byte_span_reg != 8'd0) begin
                rq_v       = 1'b1;
                rq_w       = 1'b1;
                rq_b       = 1'b1;
                rq_a       = '0;
                rq_d       = '0;
                bi_next    = 8'd1;
                phase_next = PH_BWR;
            end else begin
                phase_next = PH_BRD;
                brd_check  = 1'b1;
            end
        end

        if (brd_check) begin
            if (bi_next < byte_span_reg) begin
                rq_v      = 1'b1;
                rq_b      = 1'b1;
                rq_a      = ADDR_BITS'(bi_next);
                exp_next  = 32'(bi_next);
                pend_next = 1'b1;
            end else begin
                phase_next = PH_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            pass_reg  <= '0;
            idx_reg   <= '0;
            prng_reg  <= '0;
            exp_reg   <= '0;
            bi_reg    <= '0;
            pend_reg  <= 1'b0;
            fk_reg    <= FAIL_NONE;
            fa_reg    <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            pass_reg  <= pass_next;
            idx_reg   <= idx_next;
            prng_reg  <= prng_next;
            exp_reg   <= exp_next;
            bi_reg    <= bi_next;
            pend_reg  <= pend_next;
            fk_reg    <= fk_next;
            fa_reg    <= fa_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rq_v_reg <= rq_v;
            rq_w_reg <= rq_w;
            rq_b_reg <= rq_b;
            rq_a_reg <= rq_a;
            rq_d_reg <= rq_d;
            busy_reg <= is_running(phase_next);
            done_reg <= (phase_next == PH_DONE);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {rq_b_reg, rq_w_reg, rq_v_reg};
    assign m_tdata  = M_TDATA_W'({fa_reg, fk_reg, done_reg, busy_reg, rq_d_reg, rq_a_reg});

    // a read is outstanding only during a read sweep
    a_pend_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (phase_reg == PH_WRD || phase_reg == PH_BRD))
        else $error("read pending outside a read phase");

    // a recorded failure always ends the run
    a_fail_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (fk_reg != FAIL_NONE) |-> (phase_reg == PH_DONE))
        else $error("failure recorded while not done");

    // no request while waiting for a missing read answer
    a_wait_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && pend_reg && !in_rvalid_reg && !in_go_reg) |=> !rq_v_reg)
        else $error("request issued with a read outstanding");

    // a run in progress and a finished run are exclusive in every result
    a_busy_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(busy_reg && done_reg))
        else $error("busy and done both set");

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for the memory test sequencer: slot predictor, stream driver and monitor
`timescale 1ns / 100ps

module tb_top;
    import mts_pkg::*;

    localparam int A           = ADDR_BITS;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int OFF_WD      = A;
    localparam int OFF_BUSY    = A + 32;
    localparam int OFF_DONE    = A + 33;
    localparam int OFF_FK      = A + 34;
    localparam int OFF_FA      = A + 36;

    typedef struct packed {
        logic        go;
        logic        rd_ok;
        logic [31:0] rd_word;
    } slot_t;

    typedef struct packed {
        logic         issued;
        logic         is_write;
        logic         is_byte;
        logic [A-1:0] addr;
        logic [31:0]  wdata;
        logic         busy;
        logic         done;
        logic [1:0]   fkind;
        logic [A-1:0] faddr;
    } slot_result_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    memory_test_sequencer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // sequencer shadow state and registers
    phase_t           sq_phase;
    logic [3:0]       sq_pass;
    logic [IDX_W-1:0] sq_widx;
    logic [31:0]      sq_prng;
    logic [31:0]      sq_want;
    logic [7:0]       sq_bidx;
    logic             sq_rdwait;
    fail_kind_t       sq_fkind;
    logic [A-1:0]     sq_faddr;
    logic [15:0]      cf_count;
    logic [15:0]      cf_stride;
    logic [3:0]       cf_passes;
    logic [7:0]       cf_span;

    slot_t        mem_slot_q[$];
    slot_result_t predicted_req_q[$];

    int planned    = 0;
    int runs       = 0;
    int word_fails = 0;
    int byte_fails = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int results    = 0;

    logic s_acc   = 1'b0;
    logic m_acc   = 1'b0;
    logic cfg_acc = 1'b0;
    int   quiet   = 0;

    function automatic logic in_run(input phase_t ph);
        return ph == PH_WWR || ph == PH_WRD || ph == PH_BWR || ph == PH_BRD;
    endfunction

    function automatic logic [IDX_W-1:0] words_tested();
        return (IDX_W'(cf_count) > IDX_W'(WORD_CAP)) ? IDX_W'(WORD_CAP) : IDX_W'(cf_count);
    endfunction

    function automatic logic [IDX_W-1:0] step_words();
        return (cf_stride == 16'd0) ? IDX_W'(1) : IDX_W'(cf_stride);
    endfunction

    function automatic logic [31:0] prng_advance();
        logic [31:0] x;
        x = sq_prng;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        sq_prng = x;
        return x;
    endfunction

    // walks through empty phases until a request goes out or the run ends
    function automatic logic issue_req(output logic wr, output logic by,
                                       output logic [A-1:0] ad, output logic [31:0] wd);
        wr = 1'b0;
        by = 1'b0;
        ad = '0;
        wd = '0;
        for (int k = 0; k < 64; k++) begin
            case (sq_phase)
                PH_WWR: begin
                    if (sq_widx < words_tested()) begin
                        wr = 1'b1;
                        ad = {sq_widx[A-3:0], 2'b00};
                        wd = prng_advance();
                        sq_widx = sq_widx + step_words();
                        return 1'b1;
                    end
                    sq_widx = '0;
                    sq_prng = 32'(sq_pass);
                    sq_phase = PH_WRD;
                end
                PH_WRD: begin
                    if (sq_widx < words_tested()) begin
                        ad = {sq_widx[A-3:0], 2'b00};
                        sq_want = prng_advance();
                        sq_rdwait = 1'b1;
                        return 1'b1;
                    end
                    if (sq_pass >= cf_passes) begin
                        sq_bidx = '0;
                        sq_phase = PH_BWR;
                    end else begin
                        sq_pass = sq_pass + 4'd1;
                        sq_prng = 32'(sq_pass);
                        sq_widx = '0;
                        sq_phase = PH_WWR;
                    end
                end
                PH_BWR: begin
                    if (sq_bidx < cf_span) begin
                        wr = 1'b1;
                        by = 1'b1;
                        ad = A'(sq_bidx);
                        wd = 32'(sq_bidx);
                        sq_bidx = sq_bidx + 8'd1;
                        return 1'b1;
                    end
                    sq_bidx = '0;
                    sq_phase = PH_BRD;
                end
                PH_BRD: begin
                    if (sq_bidx < cf_span) begin
                        by = 1'b1;
                        ad = A'(sq_bidx);
                        sq_want = 32'(sq_bidx);
                        sq_rdwait = 1'b1;
                        return 1'b1;
                    end
                    sq_phase = PH_DONE;
                    return 1'b0;
                end
                default: return 1'b0;
            endcase
        end
        return 1'b0;
    endfunction

    // one memory-port slot: resolve the pending read, take a start, then issue
    task automatic sequencer_slot(input slot_t s, output slot_result_t r);
        logic         wr;
        logic         by;
        logic [A-1:0] ad;
        logic [31:0]  wd;
        logic         iss;
        iss = 1'b0;
        wr = 1'b0;
        by = 1'b0;
        ad = '0;
        wd = '0;
        if (in_run(sq_phase) && sq_rdwait && s.rd_ok) begin
            sq_rdwait = 1'b0;
            if (sq_phase == PH_WRD) begin
                if (s.rd_word == sq_want) begin
                    sq_widx = sq_widx + step_words();
                end else begin
                    sq_fkind = FAIL_WORD;
                    sq_faddr = {sq_widx[A-3:0], 2'b00};
                    sq_phase = PH_DONE;
                    word_fails++;
                end
            end else if (sq_phase == PH_BRD) begin
                if (s.rd_word[7:0] == sq_want[7:0]) begin
                    sq_bidx = sq_bidx + 8'd1;
                end else begin
                    sq_fkind = FAIL_BYTE;
                    sq_faddr = A'(sq_bidx);
                    sq_phase = PH_DONE;
                    byte_fails++;
                end
            end
        end
        if ((sq_phase == PH_IDLE || sq_phase == PH_DONE) && s.go) begin
            runs++;
            sq_fkind = FAIL_NONE;
            sq_faddr = '0;
            sq_rdwait = 1'b0;
            sq_widx = '0;
            sq_bidx = '0;
            sq_want = '0;
            if (cf_passes == 4'd0) begin
                sq_pass = '0;
                sq_prng = '0;
                sq_phase = PH_BWR;
            end else begin
                sq_pass = 4'd1;
                sq_prng = 32'd1;
                sq_phase = PH_WWR;
            end
        end
        if (in_run(sq_phase) && !sq_rdwait)
            iss = issue_req(wr, by, ad, wd);
        if (!iss) begin
            wr = 1'b0;
            by = 1'b0;
            ad = '0;
            wd = '0;
        end
        r.issued   = iss;
        r.is_write = wr;
        r.is_byte  = by;
        r.addr     = ad;
        r.wdata    = wd;
        r.busy     = in_run(sq_phase);
        r.done     = sq_phase == PH_DONE;
        r.fkind    = sq_fkind;
        r.faddr    = sq_faddr;
    endtask

    task automatic push_slot(input logic go, input logic rok, input logic [31:0] rword);
        slot_t        s;
        slot_result_t r;
        s.go = go;
        s.rd_ok = rok;
        s.rd_word = rword;
        sequencer_slot(s, r);
        mem_slot_q.push_back(s);
        predicted_req_q.push_back(r);
        planned++;
    endtask

    // answers the pending read like a memory would, with misses and corruption
    task automatic plan_slot(input logic go, input int bad_pm, input int miss_pct);
        logic        rok;
        logic [31:0] rword;
        logic [31:0] flip;
        rword = $urandom;
        if (in_run(sq_phase) && sq_rdwait) begin
            rok = $urandom_range(0, 99) >= miss_pct;
            if (rok) begin
                if (sq_phase == PH_WRD)
                    rword = sq_want;
                else
                    rword[7:0] = sq_want[7:0];
                if ($urandom_range(0, 999) < bad_pm) begin
                    if (sq_phase == PH_WRD)
                        flip = ($urandom_range(0, 1) != 0) ? (32'h1 << $urandom_range(0, 31))
                                                          : 32'($urandom);
                    else
                        flip = 32'($urandom_range(1, 255));
                    if (flip == 32'd0)
                        flip = 32'h8000_0000;
                    rword = rword ^ flip;
                end
            end
        end else begin
            rok = $urandom_range(0, 3) == 0;
        end
        push_slot(go, rok, rword);
    endtask

    task automatic plan_run(input int go_pct, input int bad_pm, input int miss_pct);
        plan_slot(1'b1, bad_pm, miss_pct);
        while (in_run(sq_phase))
            plan_slot($urandom_range(0, 99) < go_pct, bad_pm, miss_pct);
    endtask

    task automatic settle();
        while (predicted_req_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_acc);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WORD_COUNT:  cf_count  = val;
            REG_WORD_STRIDE: cf_stride = val;
            REG_PASS_COUNT:  cf_passes = val[3:0];
            REG_BYTE_SPAN:   cf_span   = val[7:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    function automatic int gap_draw(input logic calm);
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    function automatic string fmt_result(input slot_result_t r);
        return $sformatf({"req v%0b w%0b b%0b addr=%05h wdata=%08h",
                          " busy=%0b done=%0b kind=%0d faddr=%05h"},
                         r.issued, r.is_write, r.is_byte, r.addr, r.wdata,
                         r.busy, r.done, r.fkind, r.faddr);
    endfunction

    // input driver
    slot_t drv_slot;
    int    s_wait = 0;
    logic  s_calm = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_wait   <= 0;
        end else if (!s_tvalid || s_acc) begin
            if (s_wait != 0) begin
                s_wait   <= s_wait - 1;
                s_tvalid <= 1'b0;
            end else if (mem_slot_q.size() != 0) begin
                drv_slot = mem_slot_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= S_TDATA_W'({drv_slot.rd_word, drv_slot.go});
                s_tuser  <= drv_slot.rd_ok;
                s_wait   <= gap_draw(s_calm);
                if ($urandom_range(0, 39) == 0)
                    s_calm <= !s_calm;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver; a toggle of hold_token asks for one long hold-off
    logic hold_token = 1'b0;
    logic hold_seen  = 1'b0;
    int   hold_left  = 0;
    int   r_wait     = 0;
    logic r_calm     = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            r_wait    <= 0;
            hold_left <= 0;
            hold_seen <= hold_token;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (m_acc || !m_tready) begin
            if (r_wait != 0) begin
                r_wait   <= r_wait - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                r_wait   <= gap_draw(r_calm);
                if ($urandom_range(0, 39) == 0)
                    r_calm <= !r_calm;
            end
        end
    end

    // monitor, checker and watchdog
    slot_result_t got;
    slot_result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_acc   <= 1'b0;
            m_acc   <= 1'b0;
            cfg_acc <= 1'b0;
            quiet   <= 0;
        end else begin
            s_acc   <= s_tvalid && s_tready;
            m_acc   <= m_tvalid && m_tready;
            cfg_acc <= cfg_valid && cfg_ready;
            if (m_tvalid && m_tready) begin
                results++;
                got.issued   = m_tuser[0];
                got.is_write = m_tuser[1];
                got.is_byte  = m_tuser[2];
                got.addr     = m_tdata[0 +: A];
                got.wdata    = m_tdata[OFF_WD +: 32];
                got.busy     = m_tdata[OFF_BUSY];
                got.done     = m_tdata[OFF_DONE];
                got.fkind    = m_tdata[OFF_FK +: 2];
                got.faddr    = m_tdata[OFF_FA +: A];
                if (predicted_req_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d with nothing predicted: %s", results,
                                 fmt_result(got));
                end else begin
                    want = predicted_req_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch on result %0d, expected %s", results,
                                     fmt_result(want));
                            $display("  actual %s", fmt_result(got));
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", quiet);
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    initial begin
        int          pick;
        logic [15:0] cnt;
        logic [15:0] strd;
        logic [3:0]  np;
        logic [7:0]  sp;

        sq_phase  = PH_IDLE;
        sq_pass   = '0;
        sq_widx   = '0;
        sq_prng   = '0;
        sq_want   = '0;
        sq_bidx   = '0;
        sq_rdwait = 1'b0;
        sq_fkind  = FAIL_NONE;
        sq_faddr  = '0;
        cf_count  = WORD_COUNT_RST;
        cf_stride = WORD_STRIDE_RST;
        cf_passes = PASS_COUNT_RST;
        cf_span   = BYTE_SPAN_RST;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // idle slots with stray read answers
        push_slot(1'b0, 1'b1, 32'hFFFF_FFFF);
        push_slot(1'b0, 1'b0, 32'h0000_0000);
        settle();

        // short clean run, zero stride, go held high throughout, missing answers
        write_reg(REG_WORD_COUNT, 16'd3);
        write_reg(REG_WORD_STRIDE, 16'd0);
        write_reg(REG_PASS_COUNT, 16'd1);
        write_reg(REG_BYTE_SPAN, 16'd2);
        plan_run(100, 0, 30);
        settle();

        // word mismatch on the first read
        write_reg(REG_WORD_COUNT, 16'd2);
        write_reg(REG_WORD_STRIDE, 16'd1);
        write_reg(REG_BYTE_SPAN, 16'd1);
        plan_run(0, 1000, 0);
        settle();

        // no word passes, byte mismatch
        write_reg(REG_PASS_COUNT, 16'd0);
        write_reg(REG_BYTE_SPAN, 16'd3);
        plan_run(0, 1000, 0);
        settle();

        // empty runs, back to back
        write_reg(REG_WORD_COUNT, 16'd0);
        write_reg(REG_BYTE_SPAN, 16'd0);
        write_reg(REG_PASS_COUNT, 16'd2);
        plan_run(0, 0, 0);
        plan_run(0, 0, 0);
        settle();

        // register extremes: capped count, widest stride, all passes, full byte span
        write_reg(REG_WORD_COUNT, 16'hFFFF);
        write_reg(REG_WORD_STRIDE, 16'hFFFF);
        write_reg(REG_PASS_COUNT, 16'd15);
        write_reg(REG_BYTE_SPAN, 16'd255);
        plan_run(12, 0, 10);
        settle();
        write_reg(REG_WORD_COUNT, 16'h8000);
        write_reg(REG_WORD_STRIDE, 16'h4000);
        write_reg(REG_PASS_COUNT, 16'd3);
        write_reg(REG_BYTE_SPAN, 16'd8);
        plan_run(12, 20, 10);
        settle();

        // long receiver hold-off while the sender keeps offering
        write_reg(REG_WORD_COUNT, 16'd24);
        write_reg(REG_WORD_STRIDE, 16'd1);
        write_reg(REG_PASS_COUNT, 16'd2);
        write_reg(REG_BYTE_SPAN, 16'd8);
        hold_token <= ~hold_token;
        plan_run(12, 0, 5);

        // random configurations until the slot budget is used up
        while (planned < 850) begin
            if ($urandom_range(0, 2) != 0) begin
                settle();
                pick = $urandom_range(0, 19);
                cnt  = 16'($urandom_range(0, 40));
                strd = 16'($urandom_range(0, 6));
                np   = 4'($urandom_range(0, 4));
                sp   = 8'($urandom_range(0, 24));
                if (pick == 0) begin
                    cnt  = 16'($urandom_range(32768, 65535));
                    strd = 16'($urandom_range(16384, 65535));
                end else if (pick == 1) begin
                    cnt  = 16'($urandom_range(0, 3));
                    strd = 16'($urandom_range(1, 2));
                    np   = 4'($urandom_range(8, 15));
                end else if (pick == 2) begin
                    sp = 8'($urandom_range(100, 180));
                end
                write_reg(REG_WORD_COUNT, cnt);
                write_reg(REG_WORD_STRIDE, strd);
                write_reg(REG_PASS_COUNT, 16'(np));
                write_reg(REG_BYTE_SPAN, 16'(sp));
            end
            plan_run(12, 15, 8);
            repeat ($urandom_range(0, 2)) plan_slot(1'b0, 0, 0);
        end

        settle();
        repeat (16) @(negedge aclk);
        $display("covered %0d slots in %0d test runs with %0d register writes", planned, runs,
                 reg_writes);
        $display("injected %0d word and %0d byte mismatches, plus missing and stray answers",
                 word_fails, byte_fails);
        if (mismatches == 0 && predicted_req_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
